/* rtl/shm_pkg.sv */
// ----------------------------------------------------------------------------
// shm_pkg
// Shared types and constants for the sensor health hysteresis monitor.
// ----------------------------------------------------------------------------
package shm_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned ThrW    = 8;
  localparam int unsigned IdW     = 8;
  localparam int unsigned SampleW = 24;
  localparam int unsigned CfgIdxW = 3;

  // Identity values that mean the sensor did not answer
  localparam logic [IdW-1:0] IdBusLow  = 8'h00;
  localparam logic [IdW-1:0] IdBusHigh = 8'hFF;

  // Stuck or railed converter codes
  localparam logic [SampleW-1:0] SampleZero   = 24'h000000;
  localparam logic [SampleW-1:0] SampleAllOne = 24'hFFFFFF;
  localparam logic [SampleW-1:0] SampleMax    = 24'h7FFFFF;
  localparam logic [SampleW-1:0] SampleMin    = 24'h800000;

  // Configuration reset values
  localparam logic [PeriodW-1:0] PeriodRst        = 16'd500;
  localparam logic [ThrW-1:0]    MotionMissRst    = 8'd4;
  localparam logic [ThrW-1:0]    MotionHitRst     = 8'd2;
  localparam logic [ThrW-1:0]    LoadMissRst      = 8'd8;
  localparam logic [ThrW-1:0]    LoadHitRst       = 8'd2;
  localparam logic [ThrW-1:0]    LoadSuspectRst   = 8'd6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCheckPeriod   = 3'd0,
    CfgMotionMisses  = 3'd1,
    CfgMotionHits    = 3'd2,
    CfgLoadMisses    = 3'd3,
    CfgLoadHits      = 3'd4,
    CfgLoadSuspects  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic flag;
    logic checked;
  } chk_res_t;

  typedef struct packed {
    logic [ThrW-1:0] misses_to_fail;
    logic [ThrW-1:0] hits_to_pass;
    logic [ThrW-1:0] suspects_to_fail;
  } load_thr_t;

endpackage

/* rtl/shm_motion_check.sv */
// ----------------------------------------------------------------------------
// shm_motion_check
// Motion sensor identity check: period gate, hit/miss counters and flag.
// ----------------------------------------------------------------------------
module shm_motion_check #(
  parameter int unsigned COUNT_LIMIT = 255
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [shm_pkg::TimeW-1:0]  now_i,
  input  logic [shm_pkg::PeriodW-1:0] period_i,
  input  logic [shm_pkg::IdW-1:0]    id_i,
  input  logic [shm_pkg::ThrW-1:0]   misses_to_fail_i,
  input  logic [shm_pkg::ThrW-1:0]   hits_to_pass_i,
  output shm_pkg::chk_res_t          res_o
);
  import shm_pkg::*;

  localparam int unsigned CntW = $clog2(COUNT_LIMIT + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(COUNT_LIMIT);

  logic [TimeW-1:0] last_q, last_d;
  logic [CntW-1:0]  miss_q, miss_d, hit_q, hit_d;
  logic             flag_q, flag_d;
  logic [TimeW-1:0] elapsed;
  logic             due, hit;

  assign elapsed = now_i - last_q;
  assign due     = elapsed >= TimeW'(period_i);
  assign hit     = (id_i != IdBusLow) && (id_i != IdBusHigh);

  always_comb begin
    last_d = last_q;
    miss_d = miss_q;
    hit_d  = hit_q;
    flag_d = flag_q;
    if (due) begin
      last_d = now_i;
      if (hit) begin
        miss_d = '0;
        hit_d  = (hit_q < CntMax) ? hit_q + 1'b1 : hit_q;
        if (ThrW'(hit_d) >= hits_to_pass_i) flag_d = 1'b1;
      end else begin
        hit_d  = '0;
        miss_d = (miss_q < CntMax) ? miss_q + 1'b1 : miss_q;
        if (ThrW'(miss_d) >= misses_to_fail_i) flag_d = 1'b0;
      end
    end
  end

  assign res_o.flag    = flag_d;
  assign res_o.checked = due;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      miss_q <= '0;
      hit_q  <= '0;
      flag_q <= 1'b0;
    end else if (fire_i) begin
      last_q <= last_d;
      miss_q <= miss_d;
      hit_q  <= hit_d;
      flag_q <= flag_d;
    end
  end

endmodule

/* rtl/shm_load_check.sv */
// ----------------------------------------------------------------------------
// shm_load_check
// Load converter check: period gate, miss/hit/suspect counters and flag.
// ----------------------------------------------------------------------------
module shm_load_check #(
  parameter int unsigned COUNT_LIMIT = 255
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [shm_pkg::TimeW-1:0]   now_i,
  input  logic [shm_pkg::PeriodW-1:0] period_i,
  input  logic                        ready_i,
  input  logic [shm_pkg::SampleW-1:0] sample_i,
  input  shm_pkg::load_thr_t          thr_i,
  output shm_pkg::chk_res_t           res_o
);
  import shm_pkg::*;

  localparam int unsigned CntW = $clog2(COUNT_LIMIT + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(COUNT_LIMIT);

  logic [TimeW-1:0] last_q, last_d;
  logic [CntW-1:0]  miss_q, miss_d, hit_q, hit_d, susp_q, susp_d;
  logic             flag_q, flag_d;
  logic [TimeW-1:0] elapsed;
  logic             due, suspicious;

  assign elapsed    = now_i - last_q;
  assign due        = elapsed >= TimeW'(period_i);
  assign suspicious = (sample_i == SampleZero) || (sample_i == SampleAllOne) ||
                      (sample_i == SampleMax)  || (sample_i == SampleMin);

  always_comb begin
    last_d = last_q;
    miss_d = miss_q;
    hit_d  = hit_q;
    susp_d = susp_q;
    flag_d = flag_q;
    if (due) begin
      last_d = now_i;
      if (!ready_i) begin
        hit_d  = '0;
        susp_d = '0;
        miss_d = (miss_q < CntMax) ? miss_q + 1'b1 : miss_q;
        if (ThrW'(miss_d) >= thr_i.misses_to_fail) flag_d = 1'b0;
      end else if (suspicious) begin
        miss_d = '0;
        hit_d  = '0;
        susp_d = (susp_q < CntMax) ? susp_q + 1'b1 : susp_q;
        if (ThrW'(susp_d) >= thr_i.suspects_to_fail) flag_d = 1'b0;
      end else begin
        miss_d = '0;
        susp_d = '0;
        hit_d  = (hit_q < CntMax) ? hit_q + 1'b1 : hit_q;
        if (ThrW'(hit_d) >= thr_i.hits_to_pass) flag_d = 1'b1;
      end
    end
  end

  assign res_o.flag    = flag_d;
  assign res_o.checked = due;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      miss_q <= '0;
      hit_q  <= '0;
      susp_q <= '0;
      flag_q <= 1'b0;
    end else if (fire_i) begin
      last_q <= last_d;
      miss_q <= miss_d;
      hit_q  <= hit_d;
      susp_q <= susp_d;
      flag_q <= flag_d;
    end
  end

endmodule

/* rtl/sensor_health_hysteresis_monitor.sv */
// Each beat passes through an input register and then a result register.
// Throughput: one beat per cycle unless the receiver stalls; both health checks run
// in the single logic stage between the registers, which updates counters and flags.
// Reset: asynchronous, active low; clears counters, flags and last-check times,
// loads the configuration defaults and empties both registers.
// ----------------------------------------------------------------------------
// sensor_health_hysteresis_monitor
// Periodic health checks with hysteresis for a motion sensor and a load converter.
// ----------------------------------------------------------------------------
module sensor_health_hysteresis_monitor #(
  parameter int unsigned COUNT_LIMIT = 255
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [shm_pkg::TimeW-1:0]     now_ms_i,
  input  logic [shm_pkg::IdW-1:0]       motion_id_byte_i,
  input  logic                          load_sample_ready_i,
  input  logic signed [shm_pkg::SampleW-1:0] load_sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          motion_ok_o,
  output logic                          load_ok_o,
  output logic                          motion_checked_o,
  output logic                          load_checked_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [shm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [shm_pkg::PeriodW-1:0]   cfg_data_i
);
  import shm_pkg::*;

  // configuration registers
  logic [PeriodW-1:0] period_q;
  logic [ThrW-1:0]    m_miss_thr_q, m_hit_thr_q;
  load_thr_t          load_thr_q;

  // input register
  logic               s1_valid_q;
  logic [TimeW-1:0]   now_q;
  logic [IdW-1:0]     id_q;
  logic               ready_q;
  logic [SampleW-1:0] sample_q;

  // result register
  logic               out_valid_q;
  chk_res_t           m_res_q, l_res_q;

  chk_res_t           m_res, l_res;
  logic               s2_free, s1_free, fire;

  assign s2_free    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_stall_o = !s1_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q                    <= PeriodRst;
      m_miss_thr_q                <= MotionMissRst;
      m_hit_thr_q                 <= MotionHitRst;
      load_thr_q.misses_to_fail   <= LoadMissRst;
      load_thr_q.hits_to_pass     <= LoadHitRst;
      load_thr_q.suspects_to_fail <= LoadSuspectRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCheckPeriod:  period_q                    <= cfg_data_i;
        CfgMotionMisses: m_miss_thr_q                <= cfg_data_i[ThrW-1:0];
        CfgMotionHits:   m_hit_thr_q                 <= cfg_data_i[ThrW-1:0];
        CfgLoadMisses:   load_thr_q.misses_to_fail   <= cfg_data_i[ThrW-1:0];
        CfgLoadHits:     load_thr_q.hits_to_pass     <= cfg_data_i[ThrW-1:0];
        CfgLoadSuspects: load_thr_q.suspects_to_fail <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      now_q    <= now_ms_i;
      id_q     <= motion_id_byte_i;
      ready_q  <= load_sample_ready_i;
      sample_q <= load_sample_i;
    end
  end

  shm_motion_check #(
    .COUNT_LIMIT(COUNT_LIMIT)
  ) u_motion (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .now_i            (now_q),
    .period_i         (period_q),
    .id_i             (id_q),
    .misses_to_fail_i (m_miss_thr_q),
    .hits_to_pass_i   (m_hit_thr_q),
    .res_o            (m_res)
  );

  shm_load_check #(
    .COUNT_LIMIT(COUNT_LIMIT)
  ) u_load (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .now_i    (now_q),
    .period_i (period_q),
    .ready_i  (ready_q),
    .sample_i (sample_q),
    .thr_i    (load_thr_q),
    .res_o    (l_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      m_res_q <= m_res;
      l_res_q <= l_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign motion_ok_o      = m_res_q.flag;
  assign load_ok_o        = l_res_q.flag;
  assign motion_checked_o = m_res_q.checked;
  assign load_checked_o   = l_res_q.checked;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the sensor health monitor against a cycle-free model of its flags.
// Directed beats walk the check period, wrap of the millisecond clock, every
// bad identity and railed sample code and zero thresholds. Random runs then
// cover saturating counters, long and short periods and receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import shm_pkg::*;

  localparam int unsigned CountLimit = 255;

  typedef struct packed {
    logic [TimeW-1:0]   now_ms;
    logic [IdW-1:0]     id_byte;
    logic               ready;
    logic [SampleW-1:0] sample;
  } health_item_t;

  typedef struct packed {
    logic motion_ok;
    logic load_ok;
    logic motion_checked;
    logic load_checked;
  } health_result_t;

  typedef enum logic [1:0] {
    LdNotReady,
    LdSuspect,
    LdPlausible
  } load_mode_e;

  // Tracks both health flags and queues the flags each beat should produce
  class health_scoreboard;
    logic [PeriodW-1:0] period;
    logic [ThrW-1:0]    m_miss_thr, m_hit_thr, l_miss_thr, l_hit_thr, l_susp_thr;
    logic [TimeW-1:0]   motion_last, load_last;
    logic [ThrW-1:0]    m_miss_cnt, m_hit_cnt, l_miss_cnt, l_hit_cnt, l_susp_cnt;
    logic               motion_flag, load_flag;
    health_result_t     expected_flags_q[$];
    int                 mismatch_count;

    function new();
      period        = PeriodRst;
      m_miss_thr    = MotionMissRst;
      m_hit_thr     = MotionHitRst;
      l_miss_thr    = LoadMissRst;
      l_hit_thr     = LoadHitRst;
      l_susp_thr    = LoadSuspectRst;
      motion_last   = '0;
      load_last     = '0;
      m_miss_cnt    = '0;
      m_hit_cnt     = '0;
      l_miss_cnt    = '0;
      l_hit_cnt     = '0;
      l_susp_cnt    = '0;
      motion_flag   = 1'b0;
      load_flag     = 1'b0;
      mismatch_count = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [PeriodW-1:0] data);
      case (idx)
        CfgCheckPeriod:  period     = data;
        CfgMotionMisses: m_miss_thr = data[ThrW-1:0];
        CfgMotionHits:   m_hit_thr  = data[ThrW-1:0];
        CfgLoadMisses:   l_miss_thr = data[ThrW-1:0];
        CfgLoadHits:     l_hit_thr  = data[ThrW-1:0];
        CfgLoadSuspects: l_susp_thr = data[ThrW-1:0];
        default: ;
      endcase
    endfunction

    function logic [ThrW-1:0] bump(logic [ThrW-1:0] cnt);
      return (cnt < CountLimit) ? cnt + 1'b1 : cnt;
    endfunction

    function void track_sample(health_item_t it);
      health_result_t res;
      logic           railed;
      logic [TimeW-1:0] since;
      res = '0;

      since = it.now_ms - motion_last;
      if (since >= {16'd0, period}) begin
        res.motion_checked = 1'b1;
        motion_last = it.now_ms;
        if (it.id_byte != IdBusLow && it.id_byte != IdBusHigh) begin
          m_miss_cnt = '0;
          m_hit_cnt  = bump(m_hit_cnt);
          if (m_hit_cnt >= m_hit_thr) motion_flag = 1'b1;
        end else begin
          m_hit_cnt  = '0;
          m_miss_cnt = bump(m_miss_cnt);
          if (m_miss_cnt >= m_miss_thr) motion_flag = 1'b0;
        end
      end

      since = it.now_ms - load_last;
      if (since >= {16'd0, period}) begin
        res.load_checked = 1'b1;
        load_last = it.now_ms;
        if (it.ready) begin
          railed = (it.sample == SampleZero) || (it.sample == SampleAllOne) ||
                   (it.sample == SampleMax) || (it.sample == SampleMin);
          l_miss_cnt = '0;
          if (railed) begin
            l_hit_cnt  = '0;
            l_susp_cnt = bump(l_susp_cnt);
            if (l_susp_cnt >= l_susp_thr) load_flag = 1'b0;
          end else begin
            l_susp_cnt = '0;
            l_hit_cnt  = bump(l_hit_cnt);
            if (l_hit_cnt >= l_hit_thr) load_flag = 1'b1;
          end
        end else begin
          l_hit_cnt  = '0;
          l_susp_cnt = '0;
          l_miss_cnt = bump(l_miss_cnt);
          if (l_miss_cnt >= l_miss_thr) load_flag = 1'b0;
        end
      end

      res.motion_ok = motion_flag;
      res.load_ok   = load_flag;
      expected_flags_q.push_back(res);
    endfunction

    function void match_field(string name, logic exp_v, logic got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        mismatch_count++;
      end
    endfunction

    function void check_flags(health_result_t got);
      health_result_t exp_r;
      if (expected_flags_q.size() == 0) begin
        $error("result beat with no pending item");
        mismatch_count++;
        return;
      end
      exp_r = expected_flags_q.pop_front();
      match_field("motion_ok", exp_r.motion_ok, got.motion_ok);
      match_field("load_ok", exp_r.load_ok, got.load_ok);
      match_field("motion_checked", exp_r.motion_checked, got.motion_checked);
      match_field("load_checked", exp_r.load_checked, got.load_checked);
    endfunction

    function int pending();
      return expected_flags_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [TimeW-1:0]     now_ms_i = '0;
  logic [IdW-1:0]       motion_id_byte_i = '0;
  logic                 load_sample_ready_i = 1'b0;
  logic signed [SampleW-1:0] load_sample_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 motion_ok_o;
  logic                 load_ok_o;
  logic                 motion_checked_o;
  logic                 load_checked_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [PeriodW-1:0]   cfg_data_i = '0;

  health_scoreboard sb;
  int unsigned      send_idle_pct = 7;
  int unsigned      recv_idle_pct = 72;
  int unsigned      cur_period = 500;
  logic [TimeW-1:0] time_cursor = '0;
  logic             motion_good = 1'b1;
  load_mode_e       load_mode = LdPlausible;
  logic             hold_start = 1'b0;
  logic             hold_taken = 1'b0;
  int unsigned      hold_left = 0;
  logic [SampleW-1:0] rail_codes [4];

  sensor_health_hysteresis_monitor u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .now_ms_i            (now_ms_i),
    .motion_id_byte_i    (motion_id_byte_i),
    .load_sample_ready_i (load_sample_ready_i),
    .load_sample_i       (load_sample_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .motion_ok_o         (motion_ok_o),
    .load_ok_o           (load_ok_o),
    .motion_checked_o    (motion_checked_o),
    .load_checked_o      (load_checked_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("sensor_health_hysteresis_monitor: mismatch");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the pipe backs up
  always @(posedge clk_i) begin
    if (hold_start && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_left   <= 300;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : beat_monitor
    health_result_t got;
    health_item_t   seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.motion_ok      = motion_ok_o;
        got.load_ok        = load_ok_o;
        got.motion_checked = motion_checked_o;
        got.load_checked   = load_checked_o;
        sb.check_flags(got);
      end
      if (in_valid_i && !in_stall_o) begin
        seen.now_ms  = now_ms_i;
        seen.id_byte = motion_id_byte_i;
        seen.ready   = load_sample_ready_i;
        seen.sample  = load_sample_i;
        sb.track_sample(seen);
      end
    end
  end

  task automatic send_beat(health_item_t it);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    now_ms_i            <= it.now_ms;
    motion_id_byte_i    <= it.id_byte;
    load_sample_ready_i <= it.ready;
    load_sample_i       <= it.sample;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_fields(logic [TimeW-1:0] now, logic [IdW-1:0] id, logic rdy,
                             logic [SampleW-1:0] smp);
    health_item_t it;
    it.now_ms  = now;
    it.id_byte = id;
    it.ready   = rdy;
    it.sample  = smp;
    send_beat(it);
  endtask

  task automatic make_item(input logic lock, output health_item_t it);
    int unsigned pick;
    logic [31:0] rnd;
    logic [31:0] step_ms;
    pick = $urandom_range(99, 0);
    if (pick < 8) step_ms = '0;
    else if (pick < 14) step_ms = $urandom;
    else if (pick < 40) step_ms = cur_period + $urandom_range(2, 0) - 1;
    else step_ms = $urandom_range(2 * cur_period + 2, 0);
    time_cursor = time_cursor + step_ms;
    if (!lock && $urandom_range(7, 0) == 0) motion_good = !motion_good;
    if (!lock && $urandom_range(7, 0) == 0) load_mode = load_mode_e'($urandom_range(2, 0));

    it.now_ms = time_cursor;
    if (motion_good) begin
      rnd = $urandom_range(254, 1);
      it.id_byte = rnd[IdW-1:0];
    end else begin
      it.id_byte = ($urandom_range(1, 0) != 0) ? IdBusHigh : IdBusLow;
    end
    // occasional stray identity, bad or good
    if (!lock && $urandom_range(19, 0) == 0) begin
      rnd = $urandom;
      it.id_byte = rnd[IdW-1:0];
    end
    rnd = $urandom;
    it.sample = rnd[SampleW-1:0];
    it.ready  = 1'b1;
    case (load_mode)
      LdNotReady: it.ready = 1'b0;
      LdSuspect:  it.sample = rail_codes[$urandom_range(3, 0)];
      default: ;
    endcase
  endtask

  task automatic run_items(int n, logic lock);
    health_item_t it;
    repeat (n) begin
      make_item(lock, it);
      send_beat(it);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [PeriodW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(int unsigned per, int unsigned m_miss, int unsigned m_hit,
                              int unsigned l_miss, int unsigned l_hit, int unsigned l_susp);
    write_reg(CfgCheckPeriod, per[PeriodW-1:0]);
    write_reg(CfgMotionMisses, {8'd0, m_miss[ThrW-1:0]});
    write_reg(CfgMotionHits, {8'd0, m_hit[ThrW-1:0]});
    write_reg(CfgLoadMisses, {8'd0, l_miss[ThrW-1:0]});
    write_reg(CfgLoadHits, {8'd0, l_hit[ThrW-1:0]});
    write_reg(CfgLoadSuspects, {8'd0, l_susp[ThrW-1:0]});
    cfg_valid_i <= 1'b0;
    cur_period = per;
  endtask

  initial begin
    sb = new();
    rail_codes[0] = SampleZero;
    rail_codes[1] = SampleAllOne;
    rail_codes[2] = SampleMax;
    rail_codes[3] = SampleMin;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default settings: period edge, flags set then cleared by each bad code
    send_fields(32'd0, 8'h01, 1'b1, 24'd5);
    send_fields(32'd499, 8'hA5, 1'b1, 24'd5);
    send_fields(32'd500, 8'h01, 1'b1, 24'h000001);
    send_fields(32'd1000, 8'hFE, 1'b1, 24'hFFFFFE);
    send_fields(32'd1499, IdBusLow, 1'b0, 24'd0);
    send_fields(32'd1500, IdBusLow, 1'b1, SampleZero);
    send_fields(32'd2000, IdBusHigh, 1'b1, SampleAllOne);
    send_fields(32'd2500, IdBusLow, 1'b1, SampleMax);
    send_fields(32'd3000, IdBusHigh, 1'b1, SampleMin);
    send_fields(32'd3500, 8'h7F, 1'b1, SampleZero);
    send_fields(32'd4000, 8'h80, 1'b1, SampleZero);
    send_fields(32'd4500, 8'h55, 1'b0, 24'hAAAAAA);
    send_fields(32'd5000, 8'hAA, 1'b0, 24'h555555);
    // time wrap: elapsed is taken modulo 2^32
    send_fields(32'hFFFF_FFFF, 8'h01, 1'b1, 24'h7FFFFE);
    send_fields(32'h0000_01F2, 8'h02, 1'b1, 24'h800001);
    send_fields(32'h0000_01F3, 8'h03, 1'b1, 24'h800001);
    send_fields(32'h8000_0000, 8'hFE, 1'b0, 24'h800001);
    settle();

    // zero period and zero thresholds: every beat checks and acts at once
    program_regs(0, 0, 0, 0, 0, 0);
    send_fields(32'h8000_0000, IdBusLow, 1'b0, 24'h123456);
    send_fields(32'h8000_0000, 8'h01, 1'b1, 24'h654321);
    send_fields(32'h8000_0001, IdBusHigh, 1'b1, SampleMin);
    send_fields(32'h7FFF_FFFF, 8'h42, 1'b1, 24'h000002);
    send_fields(32'h7FFF_FFFF, 8'hFF, 1'b0, 24'hFFFFFF);
    settle();

    // top thresholds: long locked runs drive every counter into saturation
    time_cursor = 32'h8000_0000;
    program_regs(0, 255, 255, 255, 255, 255);
    motion_good = 1'b0;
    load_mode   = LdNotReady;
    run_items(260, 1'b1);
    motion_good = 1'b1;
    load_mode   = LdSuspect;
    run_items(260, 1'b1);
    load_mode   = LdPlausible;
    run_items(260, 1'b1);
    settle();

    send_idle_pct = 72;
    recv_idle_pct = 7;
    time_cursor   = 32'hFFFF_0000;
    program_regs(65535, $urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(8, 1),
                 $urandom_range(8, 1), $urandom_range(8, 1));
    run_items(500, 1'b0);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs($urandom_range(40, 1), $urandom_range(6, 1), $urandom_range(6, 1),
                 $urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(6, 1));
    run_items(100, 1'b0);
    hold_start <= 1'b1;
    run_items(550, 1'b0);
    settle();
    repeat (4) @(posedge clk_i);

    if (sb.mismatch_count == 0) begin
      $display("sensor_health_hysteresis_monitor: match");
    end else begin
      $display("sensor_health_hysteresis_monitor: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/shm_pkg.sv
rtl/shm_motion_check.sv
rtl/shm_load_check.sv
rtl/sensor_health_hysteresis_monitor.sv
tb/tb.sv
